/* rtl/core/ilie_pkg.sv */
`timescale 1ns / 1ps

package ilie_pkg;

  // Fixed widths of the list store and its fields
  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned STATUS_W    = 2;

  // Operation codes carried on mode
  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_ERASE  = 1'b1
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Per-cell move selection
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LO,
    CELL_FROM_HI,
    CELL_WRAP
  } cell_op_e;

  // Control bundle handed to every cell
  typedef struct packed {
    cell_op_e            op;
    logic [DATA_W-1:0]   load_data;
  } cell_ctl_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_e;

endpackage

/* rtl/core/ilie_cell.sv */
`timescale 1ns / 1ps

module ilie_cell (
  input  logic                      clk_i,
  input  ilie_pkg::cell_ctl_t       ctl_i,
  input  logic [ilie_pkg::DATA_W-1:0] lo_data_i,
  input  logic [ilie_pkg::DATA_W-1:0] hi_data_i,
  input  logic [ilie_pkg::DATA_W-1:0] head_data_i,
  output logic [ilie_pkg::DATA_W-1:0] data_o
);
  import ilie_pkg::*;

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  // Select the entry this cell takes in the next cycle
  always_comb begin
    case (ctl_i.op)
      CELL_LOAD:    data_d = ctl_i.load_data;
      CELL_FROM_LO: data_d = lo_data_i;
      CELL_FROM_HI: data_d = hi_data_i;
      CELL_WRAP:    data_d = head_data_i;
      default:      data_d = data_q;
    endcase
  end

  // Hold the entry; payload needs no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* rtl/core/indexed_list_insert_erase.sv */
`timescale 1ns / 1ps

// Ordered list of signed 32-bit entries with insert and erase by position.
// Input channel: mode_i, position_i and value_i are taken on a rising edge
// where start is high and busy is low. Insert places value_i at position_i
// (0 to current length), erase removes the entry at position_i (0 to
// length - 1). Out-of-range positions report status 1, an insert into a full
// list reports status 2; both leave the list unchanged.
// Result channel: after each item the whole list is sent, one entry per
// cycle while result_valid_o is high, entry 0 first, last_o on the final
// one. An empty list gives one result with list_empty_o set.
// Timing: the operation is applied in the accept cycle; results follow on
// the next cycles, and busy stays high until the final result has been
// sent. The list sits in a row of cells that shift in parallel; reporting
// rotates the occupied cells by one place per cycle, which sets one result
// per cycle.
// Reset empties the list (entries themselves are not cleared) and returns
// to idle. The receiver cannot stall: every result is a one-cycle transfer.

module indexed_list_insert_erase #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              mode_i,
  input  logic signed [ilie_pkg::POS_W-1:0] position_i,
  input  logic signed [ilie_pkg::DATA_W-1:0] value_i,
  output logic                              result_valid_o,
  output logic [ilie_pkg::STATUS_W-1:0]     status_o,
  output logic [ilie_pkg::IDX_W-1:0]        done_position_o,
  output logic [ilie_pkg::CNT_W-1:0]        list_length_o,
  output logic                              list_empty_o,
  output logic [ilie_pkg::IDX_W-1:0]        entry_position_o,
  output logic signed [ilie_pkg::DATA_W-1:0] entry_value_o,
  output logic                              last_o
);
  import ilie_pkg::*;

  localparam int unsigned LIMIT =
    (CAPACITY < STORE_DEPTH) ? CAPACITY : STORE_DEPTH;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [IDX_W-1:0]     done_q, done_d;

  logic                 accept;
  logic                 pos_neg;
  logic [CNT_W-1:0]     pos_u;
  logic                 ins_ok, ins_full, ers_ok;
  logic                 is_empty, is_last;
  logic [CNT_W-1:0]     last_idx;

  cell_ctl_t            cell_ctl  [LIMIT];
  logic [DATA_W-1:0]    cell_data [LIMIT];

  assign accept   = start && !busy;
  assign pos_neg  = position_i[POS_W-1];
  assign pos_u    = position_i[CNT_W-1:0];
  assign ins_ok   = !pos_neg && (pos_u <= count_q);
  assign ins_full = (count_q >= CNT_W'(LIMIT));
  assign ers_ok   = !pos_neg && (pos_u < count_q);

  assign is_empty = (count_q == '0);
  assign last_idx = count_q - CNT_W'(1);
  assign is_last  = is_empty || ({1'b0, idx_q} == last_idx);

  // Next state, operation decode and result sequencing
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    status_d = status_q;
    done_d   = done_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d  = ST_REPORT;
          idx_d    = '0;
          done_d   = '0;
          if (mode_i == MODE_INSERT) begin
            if (!ins_ok) begin
              status_d = STATUS_RANGE;
            end else if (ins_full) begin
              status_d = STATUS_FULL;
            end else begin
              status_d = STATUS_DONE;
              done_d   = pos_u[IDX_W-1:0];
              count_d  = count_q + CNT_W'(1);
            end
          end else begin
            if (!ers_ok) begin
              status_d = STATUS_RANGE;
            end else begin
              status_d = STATUS_DONE;
              done_d   = pos_u[IDX_W-1:0];
              count_d  = count_q - CNT_W'(1);
            end
          end
        end
      end
      ST_REPORT: begin
        idx_d = idx_q + IDX_W'(1);
        if (is_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Drive each cell: shift for the edit, rotate while reporting
  always_comb begin
    for (int i = 0; i < LIMIT; i++) begin
      cell_ctl[i].op        = CELL_HOLD;
      cell_ctl[i].load_data = value_i;
      if (state_q == ST_IDLE && accept) begin
        if (mode_i == MODE_INSERT && ins_ok && !ins_full) begin
          if (CNT_W'(i) == pos_u) begin
            cell_ctl[i].op = CELL_LOAD;
          end else if (CNT_W'(i) > pos_u) begin
            cell_ctl[i].op = CELL_FROM_LO;
          end
        end else if (mode_i == MODE_ERASE && ers_ok) begin
          if (CNT_W'(i) >= pos_u) begin
            cell_ctl[i].op = CELL_FROM_HI;
          end
        end
      end else if (state_q == ST_REPORT && !is_empty) begin
        if (CNT_W'(i) < last_idx) begin
          cell_ctl[i].op = CELL_FROM_HI;
        end else if (CNT_W'(i) == last_idx) begin
          cell_ctl[i].op = CELL_WRAP;
        end
      end
    end
  end

  // Row of list cells
  for (genvar g = 0; g < LIMIT; g++) begin : g_cell
    logic [DATA_W-1:0] lo_data, hi_data;
    if (g == 0) begin : g_first
      assign lo_data = cell_data[g];
    end else begin : g_inner_lo
      assign lo_data = cell_data[g-1];
    end
    if (g == LIMIT - 1) begin : g_top
      assign hi_data = cell_data[g];
    end else begin : g_inner_hi
      assign hi_data = cell_data[g+1];
    end
    ilie_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl[g]),
      .lo_data_i   (lo_data),
      .hi_data_i   (hi_data),
      .head_data_i (cell_data[0]),
      .data_o      (cell_data[g])
    );
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Hold per-item result fields
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    done_q   <= done_d;
  end

  assign busy             = (state_q != ST_IDLE);
  assign result_valid_o   = (state_q == ST_REPORT);
  assign status_o         = status_q;
  assign done_position_o  = done_q;
  assign list_length_o    = count_q;
  assign list_empty_o     = is_empty;
  assign entry_position_o = idx_q;
  assign entry_value_o    = is_empty ? '0 : $signed(cell_data[0]);
  assign last_o           = is_last;

  // Checks on sequencing
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && result_valid_o && entry_position_o == '0)
    else $error("accepted item did not start reporting");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !busy)
    else $error("block stayed busy after final result");

  a_len_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    list_length_o <= CNT_W'(LIMIT))
    else $error("list length beyond capacity");

  a_pos_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !list_empty_o |-> {1'b0, entry_position_o} < list_length_o)
    else $error("reported entry beyond list length");

  a_len_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> $stable(list_length_o) && result_valid_o)
    else $error("list length changed during report");

endmodule

/* tb/indexed_list_insert_erase_tb.sv */
`timescale 1ns / 1ps

module indexed_list_insert_erase_tb;
  import ilie_pkg::*;

  localparam int unsigned LIST_CAP     = 32;
  localparam int unsigned LIST_MAX     = (LIST_CAP < STORE_DEPTH) ? LIST_CAP : STORE_DEPTH;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS  = 20;

  // One reported list entry as the block should present it
  typedef struct packed {
    status_e                  status;
    logic [IDX_W-1:0]         done_pos;
    logic [CNT_W-1:0]         length;
    logic                     empty;
    logic [IDX_W-1:0]         entry_pos;
    logic signed [DATA_W-1:0] entry_val;
    logic                     last;
  } list_report_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     mode_i = 1'b0;
  logic signed [POS_W-1:0]  position_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     result_valid_o;
  logic [STATUS_W-1:0]      status_o;
  logic [IDX_W-1:0]         done_position_o;
  logic [CNT_W-1:0]         list_length_o;
  logic                     list_empty_o;
  logic [IDX_W-1:0]         entry_position_o;
  logic signed [DATA_W-1:0] entry_value_o;
  logic                     last_o;

  logic signed [DATA_W-1:0] shadow_list[$];
  list_report_t             expected_reports[$];
  int unsigned              error_count = 0;
  int unsigned              report_count = 0;
  int unsigned              quiet_cycles = 0;
  int unsigned              idle_pct = 0;

  indexed_list_insert_erase #(
    .CAPACITY(LIST_CAP)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .done_position_o (done_position_o),
    .list_length_o   (list_length_o),
    .list_empty_o    (list_empty_o),
    .entry_position_o(entry_position_o),
    .entry_value_o   (entry_value_o),
    .last_o          (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one operation to the shadow list and queue the full list report
  function automatic void apply_list_op(mode_e op, logic signed [POS_W-1:0] pos,
                                        logic signed [DATA_W-1:0] val);
    int               p;
    int               len;
    status_e          st;
    logic [IDX_W-1:0] done;
    list_report_t     rep;
    p    = pos;
    len  = shadow_list.size();
    st   = STATUS_DONE;
    done = '0;
    if (op == MODE_INSERT) begin
      // range check takes priority over the full check
      if (p < 0 || p > len) begin
        st = STATUS_RANGE;
      end else if (len >= int'(LIST_MAX)) begin
        st = STATUS_FULL;
      end else begin
        shadow_list.insert(p, val);
        done = p[IDX_W-1:0];
      end
    end else begin
      if (p < 0 || p >= len) begin
        st = STATUS_RANGE;
      end else begin
        shadow_list.delete(p);
        done = p[IDX_W-1:0];
      end
    end
    rep.status   = st;
    rep.done_pos = done;
    rep.length   = CNT_W'(shadow_list.size());
    if (shadow_list.size() == 0) begin
      rep.empty     = 1'b1;
      rep.entry_pos = '0;
      rep.entry_val = '0;
      rep.last      = 1'b1;
      expected_reports.push_back(rep);
    end else begin
      rep.empty = 1'b0;
      for (int i = 0; i < shadow_list.size(); i++) begin
        rep.entry_pos = IDX_W'(i);
        rep.entry_val = shadow_list[i];
        rep.last      = (i == shadow_list.size() - 1);
        expected_reports.push_back(rep);
      end
    end
  endfunction

  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch on report %0d: %s", $time, report_count, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // Drive one item, hold it until the transfer, then idle at random
  task automatic send_item(input mode_e op, input logic signed [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] val);
    start      <= 1'b1;
    mode_i     <= op;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (busy);
    apply_list_op(op, pos, val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  // Mostly legal operations with random content, some arbitrary items
  task automatic send_random_op();
    int                      len;
    mode_e                   op;
    logic signed [POS_W-1:0] pos;
    len = shadow_list.size();
    if ($urandom_range(99) < 80) begin
      if (len == 0) begin
        op = MODE_INSERT;
      end else if (len == int'(LIST_MAX)) begin
        op = ($urandom_range(3) == 0) ? MODE_INSERT : MODE_ERASE;
      end else begin
        op = ($urandom_range(99) < 55) ? MODE_INSERT : MODE_ERASE;
      end
      pos = (op == MODE_INSERT) ? POS_W'($urandom_range(len)) : POS_W'($urandom_range(len - 1));
    end else begin
      op  = mode_e'($urandom_range(1));
      pos = POS_W'($urandom());
    end
    send_item(op, pos, random_word());
  endtask

  // Edges of position and value, rejections, both ends of the list
  task automatic test_directed();
    idle_pct = 0;
    send_item(MODE_ERASE, 0, 32'h1234_5678);
    send_item(MODE_INSERT, 1, 32'h0000_0001);
    send_item(MODE_INSERT, -64, 32'h0000_0002);
    send_item(MODE_INSERT, 0, 32'h8000_0000);
    send_item(MODE_INSERT, 1, 32'h7fff_ffff);
    send_item(MODE_INSERT, 0, 32'hffff_ffff);
    send_item(MODE_INSERT, 3, 32'h0000_0000);
    send_item(MODE_INSERT, 2, 32'h5a5a_5a5a);
    send_item(MODE_ERASE, -1, 32'h0000_0000);
    send_item(MODE_ERASE, 5, 32'h0000_0000);
    send_item(MODE_INSERT, 63, 32'ha5a5_a5a5);
    send_item(MODE_ERASE, 63, 32'h0000_0000);
    send_item(MODE_ERASE, 2, 32'hdead_beef);
    send_item(MODE_ERASE, 0, 32'h0000_0000);
    send_item(MODE_ERASE, 2, 32'h0000_0000);
    send_item(MODE_ERASE, 0, 32'h0000_0000);
    send_item(MODE_ERASE, 0, 32'h0000_0000);
    send_item(MODE_INSERT, -1, 32'h0000_0003);
  endtask

  // Fill to capacity, hit the full status, then drain back to empty
  task automatic test_full_list();
    idle_pct = 16;
    while (shadow_list.size() < LIST_MAX) begin
      send_item(MODE_INSERT, POS_W'($urandom_range(shadow_list.size())), random_word());
    end
    send_item(MODE_INSERT, 0, random_word());
    send_item(MODE_INSERT, POS_W'(LIST_MAX), random_word());
    send_item(MODE_INSERT, POS_W'(LIST_MAX + 1), random_word());
    send_item(MODE_INSERT, -1, random_word());
    send_item(MODE_ERASE, POS_W'(LIST_MAX - 1), random_word());
    send_item(MODE_INSERT, POS_W'(LIST_MAX - 1), random_word());
    // hold off until the whole full-list report has been seen
    wait_until_drained();
    while (shadow_list.size() > 0) begin
      send_item(MODE_ERASE, POS_W'($urandom_range(shadow_list.size() - 1)), random_word());
    end
  endtask

  task automatic test_random_phases();
    int unsigned phase_idle[4];
    phase_idle = '{0, 57, 0, 16};
    foreach (phase_idle[k]) begin
      idle_pct = phase_idle[k];
      repeat (PHASE_ITEMS) send_random_op();
    end
  endtask

  // Check every result transfer against the oldest expected report
  always @(posedge clk_i) begin : result_check
    list_report_t want;
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (result_valid_o) begin
        report_count++;
        if (expected_reports.size() == 0) begin
          report_mismatch("result with no report expected");
        end else begin
          want = expected_reports.pop_front();
          check_field("status", status_o, want.status);
          check_field("done_position", done_position_o, want.done_pos);
          check_field("list_length", list_length_o, want.length);
          check_field("list_empty", list_empty_o, want.empty);
          check_field("entry_position", entry_position_o, want.entry_pos);
          check_field("entry_value", entry_value_o, want.entry_val);
          check_field("last", last_o, want.last);
        end
      end
    end
  end

  // Stop the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("indexed_list_insert_erase verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_list();
    test_random_phases();
    wait_until_drained();
    // leave room for any stray results
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("indexed_list_insert_erase verification clean");
    end else begin
      $display("indexed_list_insert_erase verification failed");
    end
    $finish;
  end

endmodule
